FILE: design/spa_pkg.sv
// Shared widths, operation and status codes, sequencer states and saturating add.
package spa_pkg;

  localparam int MAX_TERMS_DEFAULT = 16;
  localparam int COEF_W            = 32;
  localparam int EXP_W             = 16;
  localparam int OP_W              = 2;
  localparam int STATUS_W          = 2;

  localparam logic [OP_W-1:0] OP_INSERT_A = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT_B = 2'd1;
  localparam logic [OP_W-1:0] OP_EMIT     = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_VALID = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_SHIFT,
    S_MOVE,
    S_MERGE_RD,
    S_MERGE,
    S_REPORT
  } state_t;

  // Two's complement add that clamps to the coefficient range.
  function automatic logic signed [COEF_W-1:0] sat_add(input logic signed [COEF_W-1:0] x,
                                                       input logic signed [COEF_W-1:0] y);
    logic signed [COEF_W:0] s;
    s = {x[COEF_W-1], x} + {y[COEF_W-1], y};
    if (s[COEF_W] != s[COEF_W-1]) begin
      return s[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end
    return s[COEF_W-1:0];
  endfunction

endpackage

FILE: design/spa_in_if.sv
// Term input channel: valid/ready handshake with operation, coefficient and exponent.
interface spa_in_if import spa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [COEF_W-1:0] coefficient;
  logic [EXP_W-1:0]         exponent;

  modport source (output valid, output operation, output coefficient, output exponent,
                  input ready);
  modport sink (input valid, input operation, input coefficient, input exponent,
                output ready);
endinterface

FILE: design/spa_out_if.sv
// Sum output channel: valid/ready handshake with one result term and its status.
interface spa_out_if import spa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] sum_coefficient;
  logic [EXP_W-1:0]         sum_exponent;
  logic                     last;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output sum_coefficient, output sum_exponent, output last,
                  output status, input ready);
  modport sink (input valid, input sum_coefficient, input sum_exponent, input last,
                input status, output ready);
endinterface

FILE: design/sparse_polynomial_adder.sv
// Top level: sparse polynomial adder with two sorted term tables in RAM and a merge sequencer.
//
// term_in carries one operation per transfer: insert a term into table A, insert into
// table B, or emit the sum. Each table holds up to MAX_TERMS terms sorted by descending
// exponent in its own RAM. An insert walks the table, one RAM read and one compare
// per entry, to find the spot, adds into an equal exponent through the shared
// saturating adder, or opens a gap by moving the tail down one entry at a time.
// An insert that finds the table full with a new exponent returns one STATUS_FULL
// result with last set.
// An emit merges both tables, one result term per RAM read and compare-and-add step,
// marks the final term with last and then empties both tables.
// An emit with both tables empty returns one STATUS_EMPTY result.
// term_in.ready is high only while the sequencer is idle; one operation is in work
// at a time. Results leave through an output register: when sum_out stalls, the
// sequencer holds its merge position and resumes on the next free slot, so no term
// is lost or repeated.
// Reset empties both tables and the output register; the RAM contents are not
// cleared, since entries past the fill count are never used.
module sparse_polynomial_adder import spa_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  spa_in_if.sink     term_in,
  spa_out_if.source  sum_out
);

  localparam int IDX_W  = $clog2(MAX_TERMS);
  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int WORD_W = COEF_W + EXP_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_TERMS);
  localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);

  // sequencer and table fill state
  state_t              state, state_next;
  logic [CNT_W-1:0]    count_a, count_a_next;
  logic [CNT_W-1:0]    count_b, count_b_next;

  // operation in work
  logic                sel_b, sel_b_next;
  logic signed [COEF_W-1:0] coef_r, coef_r_next;
  logic [EXP_W-1:0]    exp_r, exp_r_next;
  logic [CNT_W-1:0]    idx, idx_next;
  logic [CNT_W-1:0]    pos, pos_next;
  logic [CNT_W-1:0]    ia, ia_next;
  logic [CNT_W-1:0]    ib, ib_next;
  logic [STATUS_W-1:0] rep_status, rep_status_next;

  // output register
  logic                out_valid, out_valid_next;
  logic signed [COEF_W-1:0] out_coef, out_coef_next;
  logic [EXP_W-1:0]    out_exp, out_exp_next;
  logic                out_last, out_last_next;
  logic [STATUS_W-1:0] out_status, out_status_next;

  // RAM ports
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [WORD_W-1:0]   wdata;
  logic [IDX_W-1:0]    raddr_a, raddr_b;
  logic [WORD_W-1:0]   rdata_a, rdata_b;

  // datapath
  logic                in_xfer;
  logic                out_free;
  logic                load_out;
  logic [CNT_W-1:0]    count_sel;
  logic                full_sel;
  logic [WORD_W-1:0]   rd_sel;
  logic signed [COEF_W-1:0] rd_coef, a_coef, b_coef;
  logic [EXP_W-1:0]    rd_exp, a_exp, b_exp;
  logic signed [COEF_W-1:0] add_x, add_y, add_sum;
  logic [EXP_W-1:0]    cmp_x, cmp_y;
  logic                cmp_gt, cmp_eq;
  logic                a_live, b_live, take_a, take_b;
  logic [CNT_W-1:0]    ia_adv, ib_adv;
  logic                merge_last;
  logic [CNT_W-1:0]    idx_inc;

  spa_ram #(.WIDTH(WORD_W), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk   (clk),
    .we    (we && !sel_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  spa_ram #(.WIDTH(WORD_W), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk   (clk),
    .we    (we && sel_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  assign in_xfer  = term_in.valid && term_in.ready;
  assign out_free = !out_valid || sum_out.ready;

  assign count_sel = sel_b ? count_b : count_a;
  assign full_sel  = (count_sel == FULL_COUNT);
  assign idx_inc   = idx + ONE;

  assign rd_sel  = sel_b ? rdata_b : rdata_a;
  assign rd_coef = rd_sel[WORD_W-1:EXP_W];
  assign rd_exp  = rd_sel[EXP_W-1:0];
  assign a_coef  = rdata_a[WORD_W-1:EXP_W];
  assign a_exp   = rdata_a[EXP_W-1:0];
  assign b_coef  = rdata_b[WORD_W-1:EXP_W];
  assign b_exp   = rdata_b[EXP_W-1:0];

  // Shared saturating adder and exponent comparator: merge heads while merging,
  // otherwise the stored entry against the incoming term.
  always_comb begin
    if (state == S_MERGE) begin
      add_x = a_coef;
      add_y = b_coef;
      cmp_x = a_exp;
      cmp_y = b_exp;
    end else begin
      add_x = rd_coef;
      add_y = coef_r;
      cmp_x = rd_exp;
      cmp_y = exp_r;
    end
  end

  assign add_sum = sat_add(add_x, add_y);
  assign cmp_gt  = (cmp_x > cmp_y);
  assign cmp_eq  = (cmp_x == cmp_y);

  // Merge decision: an equal pair advances both heads.
  assign a_live     = (ia < count_a);
  assign b_live     = (ib < count_b);
  assign take_a     = a_live && (!b_live || cmp_gt || cmp_eq);
  assign take_b     = b_live && (!a_live || !cmp_gt);
  assign ia_adv     = ia + CNT_W'(take_a);
  assign ib_adv     = ib + CNT_W'(take_b);
  assign merge_last = (ia_adv == count_a) && (ib_adv == count_b);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          case (term_in.operation)
            OP_INSERT_A: state_next = (count_a == '0) ? S_SHIFT : S_SEARCH;
            OP_INSERT_B: state_next = (count_b == '0) ? S_SHIFT : S_SEARCH;
            OP_EMIT: begin
              state_next = (count_a == '0 && count_b == '0) ? S_REPORT : S_MERGE_RD;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SEARCH: state_next = S_COMPARE;
      S_COMPARE: begin
        if (cmp_eq) begin
          state_next = S_IDLE;
        end else if (cmp_gt && idx_inc != count_sel) begin
          state_next = S_SEARCH;
        end else begin
          state_next = full_sel ? S_REPORT : S_SHIFT;
        end
      end
      S_SHIFT: state_next = (idx == pos) ? S_IDLE : S_MOVE;
      S_MOVE: state_next = S_SHIFT;
      S_MERGE_RD: state_next = S_MERGE;
      S_MERGE: begin
        if (out_free) begin
          state_next = merge_last ? S_IDLE : S_MERGE_RD;
        end
      end
      S_REPORT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath controls, RAM ports and output register loads
  always_comb begin
    sel_b_next      = sel_b;
    coef_r_next     = coef_r;
    exp_r_next      = exp_r;
    idx_next        = idx;
    pos_next        = pos;
    ia_next         = ia;
    ib_next         = ib;
    rep_status_next = rep_status;
    count_a_next    = count_a;
    count_b_next    = count_b;
    we              = 1'b0;
    waddr           = '0;
    wdata           = {coef_r, exp_r};
    raddr_a         = '0;
    raddr_b         = '0;
    load_out        = 1'b0;
    out_coef_next   = out_coef;
    out_exp_next    = out_exp;
    out_last_next   = out_last;
    out_status_next = out_status;

    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          sel_b_next      = (term_in.operation == OP_INSERT_B);
          coef_r_next     = term_in.coefficient;
          exp_r_next      = term_in.exponent;
          idx_next        = '0;
          pos_next        = '0;
          ia_next         = '0;
          ib_next         = '0;
          rep_status_next = STATUS_EMPTY;
        end
      end
      S_SEARCH: begin
        raddr_a = idx[IDX_W-1:0];
        raddr_b = idx[IDX_W-1:0];
      end
      S_COMPARE: begin
        rep_status_next = STATUS_FULL;
        if (cmp_eq) begin
          // existing exponent: add in place, even into a full table
          we    = 1'b1;
          waddr = idx[IDX_W-1:0];
          wdata = {add_sum, exp_r};
        end else if (cmp_gt && idx_inc != count_sel) begin
          idx_next = idx_inc;
        end else begin
          pos_next = cmp_gt ? count_sel : idx;
          idx_next = count_sel;
        end
      end
      S_SHIFT: begin
        if (idx == pos) begin
          we    = 1'b1;
          waddr = pos[IDX_W-1:0];
          if (sel_b) begin
            count_b_next = count_b + ONE;
          end else begin
            count_a_next = count_a + ONE;
          end
        end else begin
          raddr_a = IDX_W'(idx - ONE);
          raddr_b = IDX_W'(idx - ONE);
        end
      end
      S_MOVE: begin
        // move the entry read last cycle down one place
        we       = 1'b1;
        waddr    = idx[IDX_W-1:0];
        wdata    = rd_sel;
        idx_next = idx - ONE;
      end
      S_MERGE_RD: begin
        raddr_a = a_live ? ia[IDX_W-1:0] : '0;
        raddr_b = b_live ? ib[IDX_W-1:0] : '0;
      end
      S_MERGE: begin
        // hold the head addresses so a stalled merge keeps its read data
        raddr_a = a_live ? ia[IDX_W-1:0] : '0;
        raddr_b = b_live ? ib[IDX_W-1:0] : '0;
        if (out_free) begin
          load_out        = 1'b1;
          out_coef_next   = (take_a && take_b) ? add_sum : (take_a ? a_coef : b_coef);
          out_exp_next    = take_a ? a_exp : b_exp;
          out_last_next   = merge_last;
          out_status_next = STATUS_VALID;
          ia_next         = ia_adv;
          ib_next         = ib_adv;
          if (merge_last) begin
            count_a_next = '0;
            count_b_next = '0;
          end
        end
      end
      S_REPORT: begin
        if (out_free) begin
          load_out        = 1'b1;
          out_coef_next   = '0;
          out_exp_next    = '0;
          out_last_next   = 1'b1;
          out_status_next = rep_status;
        end
      end
      default: begin
      end
    endcase

    out_valid_next = load_out ? 1'b1 : (out_valid && !sum_out.ready);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_a   <= '0;
      count_b   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count_a   <= count_a_next;
      count_b   <= count_b_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    sel_b      <= sel_b_next;
    coef_r     <= coef_r_next;
    exp_r      <= exp_r_next;
    idx        <= idx_next;
    pos        <= pos_next;
    ia         <= ia_next;
    ib         <= ib_next;
    rep_status <= rep_status_next;
    out_coef   <= out_coef_next;
    out_exp    <= out_exp_next;
    out_last   <= out_last_next;
    out_status <= out_status_next;
  end

  assign term_in.ready           = (state == S_IDLE);
  assign sum_out.valid           = out_valid;
  assign sum_out.sum_coefficient = out_coef;
  assign sum_out.sum_exponent    = out_exp;
  assign sum_out.last            = out_last;
  assign sum_out.status          = out_status;

  // Fill counts never pass the table depth.
  assert property (@(posedge clk) disable iff (rst)
    count_a <= FULL_COUNT && count_b <= FULL_COUNT)
    else $error("table fill count beyond depth");

  // The final merged term empties both tables.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE && load_out && merge_last) |=> (count_a == '0 && count_b == '0))
    else $error("tables not cleared after emit");

  // No table write while idle.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we)
    else $error("table write while idle");

  // Table A's fill count grows by one or drops to zero.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count_a != $past(count_a)) |->
      (count_a == $past(count_a) + ONE || count_a == '0))
    else $error("table A fill count jumped");

  // Full and empty reports are always single, final results.
  assert property (@(posedge clk) disable iff (rst)
    (sum_out.valid && sum_out.status != STATUS_VALID) |->
      (sum_out.last && sum_out.sum_exponent == '0))
    else $error("status result not final");

endmodule

FILE: design/spa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
